@@ sv/wrm_pkg.sv @@
// package for the wildcard regex row matcher: sizes, symbol codes, kinds and link types
`default_nettype none

package wrm_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int SYM_W       = 8;

    localparam logic [SYM_W-1:0] SYM_ANY  = 8'h2E;
    localparam logic [SYM_W-1:0] SYM_STAR = 8'h2A;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_FEED   = 2'd2,
        KIND_END    = 2'd3
    } kind_t;

    // broadcast to every cell for one accepted transaction
    typedef struct packed {
        logic             fire;
        kind_t            kind;
        logic [SYM_W-1:0] symbol;
        logic             full;
    } cmd_t;

    // what a cell hands to its right-hand neighbors
    typedef struct packed {
        logic [SYM_W-1:0] chr;
        logic             is_char;
        logic             valid;
        logic             cur;
        logic             empty;
        logic             nxt;
    } link_t;

endpackage

`default_nettype wire

@@ sv/wrm_cell.sv @@
// one pattern position: stored byte, empty-subject bit and current row bit
`default_nettype none

module wrm_cell (
    input  wire            aclk,
    input  wire            aresetn,
    input  wrm_pkg::cmd_t  cmd,
    input  wrm_pkg::link_t left1,
    input  wrm_pkg::link_t left2,
    output wrm_pkg::link_t self_link
);

    logic [wrm_pkg::SYM_W-1:0] char_reg;
    logic [wrm_pkg::SYM_W-1:0] char_next;
    logic                      valid_reg;
    logic                      valid_next;
    logic                      empty_reg;
    logic                      empty_next;
    logic                      cur_reg;
    logic                      cur_next;

    logic lit_hit;
    logic star_here;
    logic prev_hit;
    logic nxt;
    logic target;

    always_comb begin
        lit_hit   = (char_reg == cmd.symbol) || (char_reg == wrm_pkg::SYM_ANY);
        star_here = (char_reg == wrm_pkg::SYM_STAR) && left1.is_char;
        prev_hit  = (left1.chr == wrm_pkg::SYM_ANY) || (left1.chr == cmd.symbol);
        if (!valid_reg) begin
            nxt = 1'b0;
        end else if (lit_hit) begin
            nxt = left1.cur;
        end else if (star_here) begin
            nxt = left2.nxt | (prev_hit & (left2.cur | cur_reg));
        end else begin
            nxt = 1'b0;
        end
        target = left1.valid & ~valid_reg;
    end

    always_comb begin
        char_next  = char_reg;
        valid_next = valid_reg;
        empty_next = empty_reg;
        cur_next   = cur_reg;
        if (cmd.fire) begin
            case (cmd.kind)
                wrm_pkg::KIND_CLEAR: begin
                    valid_next = 1'b0;
                    empty_next = 1'b0;
                    cur_next   = 1'b0;
                end
                wrm_pkg::KIND_APPEND: begin
                    if (target) begin
                        char_next  = cmd.symbol;
                        valid_next = 1'b1;
                        empty_next = (cmd.symbol == wrm_pkg::SYM_STAR) && left1.is_char
                                     && left2.empty;
                    end
                    if (!cmd.full) begin
                        cur_next = empty_next;
                    end
                end
                wrm_pkg::KIND_FEED: begin
                    cur_next = nxt;
                end
                wrm_pkg::KIND_END: begin
                    cur_next = empty_reg;
                end
                default: begin
                    cur_next = cur_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            empty_reg <= 1'b0;
            cur_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            empty_reg <= empty_next;
            cur_reg   <= cur_next;
        end
    end

    always_comb begin
        self_link.chr     = char_reg;
        self_link.is_char = 1'b1;
        self_link.valid   = valid_reg;
        self_link.cur     = cur_reg;
        self_link.empty   = empty_reg;
        self_link.nxt     = nxt;
    end

endmodule

`default_nettype wire

@@ sv/wildcard_regex_row_matcher_top.sv @@
// top level: row of pattern cells, length and overflow tracking, result register
// result: registered onto m_tdata in the cycle after an end-of-subject transaction is accepted
// throughput: one transaction per cycle while no result is pending or m_tready is high;
// the cell row updates together, with a short ripple through every second cell for star terms
// reset: synchronous active-low aresetn empties the pattern, clears the overflow
// flag and sets the row to bit zero only; no clearing pass is needed
`default_nettype none

module wildcard_regex_row_matcher_top (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,   // symbol
    input  wire  [1:0] s_tuser,   // kind
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata    // matched, pattern_overflow, zero fill
);

    localparam int N = wrm_pkg::MAX_PATTERN;

    wrm_pkg::cmd_t  cmd;
    wrm_pkg::link_t lnk [0:N+1];
    logic [N:0]     row;

    logic                    cur0_reg;
    logic                    cur0_next;
    logic [wrm_pkg::LEN_W-1:0] len_reg;
    logic [wrm_pkg::LEN_W-1:0] len_next;
    logic                    ovf_reg;
    logic                    ovf_next;
    logic                    m_valid_reg;
    logic                    m_valid_next;
    logic [1:0]              m_data_reg;
    logic [1:0]              m_data_next;
    logic                    s_fire;

    assign s_tready = ~m_valid_reg | m_tready;
    assign s_fire   = s_tvalid & s_tready;

    always_comb begin
        cmd.fire   = s_fire;
        cmd.kind   = wrm_pkg::kind_t'(s_tuser);
        cmd.symbol = s_tdata;
        cmd.full   = (len_reg == wrm_pkg::LEN_W'(N));
    end

    // position before the first cell, then the start cell of the row
    assign lnk[0] = '0;
    assign lnk[1] = '{chr: '0, is_char: 1'b0, valid: 1'b1, cur: cur0_reg,
                      empty: 1'b1, nxt: 1'b0};

    genvar j;
    generate
        for (j = 1; j <= N; j++) begin : g_cell
            wrm_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .cmd       (cmd),
                .left1     (lnk[j]),
                .left2     (lnk[j-1]),
                .self_link (lnk[j+1])
            );
        end
        for (j = 0; j <= N; j++) begin : g_row
            assign row[j] = lnk[j+1].cur;
        end
    endgenerate

    always_comb begin
        cur0_next    = cur0_reg;
        len_next     = len_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        m_data_next  = m_data_reg;
        if (s_fire) begin
            case (cmd.kind)
                wrm_pkg::KIND_CLEAR: begin
                    cur0_next = 1'b1;
                    len_next  = '0;
                    ovf_next  = 1'b0;
                end
                wrm_pkg::KIND_APPEND: begin
                    if (cmd.full) begin
                        ovf_next = 1'b1;
                    end else begin
                        len_next  = len_reg + 1'b1;
                        cur0_next = 1'b1;
                    end
                end
                wrm_pkg::KIND_FEED: begin
                    cur0_next = 1'b0;
                end
                wrm_pkg::KIND_END: begin
                    cur0_next    = 1'b1;
                    m_valid_next = 1'b1;
                    m_data_next  = {ovf_reg, row[len_reg]};
                end
                default: begin
                    cur0_next = cur0_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur0_reg    <= 1'b1;
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cur0_reg    <= cur0_next;
            len_reg     <= len_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_data_reg};

endmodule

`default_nettype wire
